@@ rtl/core/pdri_pkg.sv @@
// Shared types, constants and the arctangent table for the pose integrator.
package pdri_pkg;

    localparam int ITER_W   = 5;
    localparam int ATAN_LEN = 24;
    localparam int X_W      = 36;
    localparam int Z_W      = 34;
    localparam int MA_W     = 34;
    localparam int MB_W     = 31;
    localparam int PROD_W   = MA_W + MB_W;

    localparam logic signed [MB_W-1:0] INV_GAIN_Q30  = 31'sd652032874;
    localparam logic signed [MB_W-1:0] RAD_TO_BAM_Q16 = 31'sd683565276;

    localparam logic [ITER_W-1:0] SCALE_LAST = 5'd6;

    localparam logic [1:0] REG_INIT_X       = 2'd0;
    localparam logic [1:0] REG_INIT_Y       = 2'd1;
    localparam logic [1:0] REG_INIT_HEADING = 2'd2;

    localparam logic [15:0] QUARTER_TURN = 16'h4000;
    localparam logic [15:0] HALF_TURN    = 16'h8000;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROTATE,
        ST_SCALE,
        ST_WRITE
    } state_t;

    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_XLO,
        MUL_XHI,
        MUL_YLO,
        MUL_YHI,
        MUL_RXDT,
        MUL_RYDT,
        MUL_WDT,
        MUL_WBAM
    } mul_op_t;

    typedef struct packed {
        logic              start;
        logic              rotate;
        logic [ITER_W-1:0] iter;
        mul_op_t           mul_op;
        logic              write;
        logic              load;
    } cmd_t;

    function automatic logic signed [Z_W-1:0] atan_entry(input logic [ITER_W-1:0] idx);
        logic signed [Z_W-1:0] v;
        case (idx)
            5'd0:    v = 34'sh020000000;
            5'd1:    v = 34'sh012E4051E;
            5'd2:    v = 34'sh009FB385B;
            5'd3:    v = 34'sh0051111D4;
            5'd4:    v = 34'sh0028B0D43;
            5'd5:    v = 34'sh00145D7E1;
            5'd6:    v = 34'sh000A2F61E;
            5'd7:    v = 34'sh000517C55;
            5'd8:    v = 34'sh00028BE53;
            5'd9:    v = 34'sh000145F2F;
            5'd10:   v = 34'sh0000A2F98;
            5'd11:   v = 34'sh0000517CC;
            5'd12:   v = 34'sh000028BE6;
            5'd13:   v = 34'sh0000145F3;
            5'd14:   v = 34'sh00000A2FA;
            5'd15:   v = 34'sh00000517D;
            5'd16:   v = 34'sh0000028BE;
            5'd17:   v = 34'sh00000145F;
            5'd18:   v = 34'sh000000A30;
            5'd19:   v = 34'sh000000518;
            5'd20:   v = 34'sh00000028C;
            5'd21:   v = 34'sh000000146;
            5'd22:   v = 34'sh0000000A3;
            5'd23:   v = 34'sh000000051;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/core/pdri_regs.sv @@
// APB register file holding the initial pose.
module pdri_regs
    import pdri_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [31:0] init_x,
    output logic [31:0] init_y,
    output logic [15:0] init_heading
);

    logic [31:0] init_x_reg;
    logic [31:0] init_y_reg;
    logic [15:0] init_heading_reg;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_x_reg       <= '0;
            init_y_reg       <= '0;
            init_heading_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (paddr[3:2])
                REG_INIT_X:       init_x_reg       <= pwdata;
                REG_INIT_Y:       init_y_reg       <= pwdata;
                REG_INIT_HEADING: init_heading_reg <= pwdata[15:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_INIT_X:       prdata = init_x_reg;
            REG_INIT_Y:       prdata = init_y_reg;
            REG_INIT_HEADING: prdata = {16'b0, init_heading_reg};
            default:          prdata = '0;
        endcase
    end

    assign init_x       = init_x_reg;
    assign init_y       = init_y_reg;
    assign init_heading = init_heading_reg;

endmodule

@@ rtl/core/pdri_ctrl.sv @@
// Sequencer: CORDIC iterations, multiplier schedule and output handshake.
module pdri_ctrl
    import pdri_pkg::*;
#(
    parameter int CORDIC_ITERATIONS = 16
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  logic op,
    output logic out_valid,
    input  logic out_stall,
    output cmd_t cmd
);

    state_t            state_reg, state_next;
    logic [ITER_W-1:0] cnt_reg, cnt_next;
    logic              op_reg, op_next;
    logic              out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            op_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            op_reg        <= op_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        op_next        = op_reg;
        out_valid_next = out_valid_reg && out_stall;
        in_stall       = 1'b1;
        cmd            = '{start: 1'b0, rotate: 1'b0, iter: '0, mul_op: MUL_NONE,
                           write: 1'b0, load: 1'b0};
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    op_next    = op;
                    cnt_next   = '0;
                    state_next = op ? ST_WRITE : ST_ROTATE;
                end
            end
            ST_ROTATE:
            begin
                cmd.rotate = 1'b1;
                cmd.iter   = cnt_reg;
                // heading products ride along while the rotation runs
                if (cnt_reg == 5'd0)
                    cmd.mul_op = MUL_WDT;
                else if (cnt_reg == 5'd1)
                    cmd.mul_op = MUL_WBAM;
                if (cnt_reg == ITER_W'(CORDIC_ITERATIONS - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_SCALE;
                end
                else
                    cnt_next = cnt_reg + 5'd1;
            end
            ST_SCALE:
            begin
                case (cnt_reg)
                    5'd0:    cmd.mul_op = MUL_XLO;
                    5'd1:    cmd.mul_op = MUL_YLO;
                    5'd2:    cmd.mul_op = MUL_XHI;
                    5'd3:    cmd.mul_op = MUL_YHI;
                    5'd4:    cmd.mul_op = MUL_RXDT;
                    5'd5:    cmd.mul_op = MUL_RYDT;
                    default: cmd.mul_op = MUL_NONE;
                endcase
                if (cnt_reg == SCALE_LAST)
                    state_next = ST_WRITE;
                else
                    cnt_next = cnt_reg + 5'd1;
            end
            ST_WRITE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.write      = 1'b1;
                    cmd.load       = op_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

@@ rtl/core/pdri_datapath.sv @@
// Pose state, CORDIC rotator, shared multiplier and output registers.
module pdri_datapath
    import pdri_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               cmd,
    input  logic signed [15:0] vel_x,
    input  logic signed [15:0] vel_y,
    input  logic signed [15:0] yaw_rate,
    input  logic [15:0]        elapsed,
    input  logic [31:0]        init_x,
    input  logic [31:0]        init_y,
    input  logic [15:0]        init_heading,
    output logic signed [31:0] pos_x,
    output logic signed [31:0] pos_y,
    output logic [15:0]        heading
);

    localparam logic signed [31:0] POS_MAX = 32'sh7FFFFFFF;
    localparam logic signed [31:0] POS_MIN = 32'sh80000000;

    logic signed [X_W-1:0]    x_reg, y_reg;
    logic signed [Z_W-1:0]    z_reg;
    logic signed [15:0]       yaw_reg;
    logic [15:0]              dt_reg;
    logic signed [PROD_W-1:0] prod_reg;
    mul_op_t                  tag_reg;
    logic [47:0]              gx_reg, gy_reg;
    logic signed [MA_W-1:0]   rx_reg, ry_reg;
    logic signed [MA_W-1:0]   dx_reg, dy_reg;
    logic [15:0]              dh_reg;
    logic signed [31:0]       pose_x_reg, pose_y_reg;
    logic [15:0]              pose_h_reg;
    logic signed [31:0]       pos_x_reg, pos_y_reg;
    logic [15:0]              heading_reg;

    // quadrant fold and CORDIC seed
    logic                     fold;
    logic signed [16:0]       vx_ext, vy_ext, vx_f, vy_f;
    logic [15:0]              h_f;

    assign fold   = ((pose_h_reg + QUARTER_TURN) & HALF_TURN) != 16'h0;
    assign vx_ext = 17'(vel_x);
    assign vy_ext = 17'(vel_y);
    assign vx_f   = fold ? -vx_ext : vx_ext;
    assign vy_f   = fold ? -vy_ext : vy_ext;
    assign h_f    = fold ? (pose_h_reg ^ HALF_TURN) : pose_h_reg;

    logic signed [X_W-1:0] xs, ys;
    logic signed [Z_W-1:0] atan_v;

    assign xs     = x_reg >>> cmd.iter;
    assign ys     = y_reg >>> cmd.iter;
    assign atan_v = atan_entry(cmd.iter);

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            x_reg   <= {{3{vx_f[16]}}, vx_f, 16'b0};
            y_reg   <= {{3{vy_f[16]}}, vy_f, 16'b0};
            z_reg   <= {{2{h_f[15]}}, h_f, 16'b0};
            yaw_reg <= yaw_rate;
            dt_reg  <= elapsed;
        end
        else if (cmd.rotate)
        begin
            if (!z_reg[Z_W-1])
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - atan_v;
            end
            else
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + atan_v;
            end
        end
    end

    // shared multiplier
    logic signed [MA_W-1:0] mul_a;
    logic signed [MB_W-1:0] mul_b;
    logic signed [MB_W-1:0] dt_b;

    assign dt_b = $signed({15'b0, dt_reg});

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.mul_op)
            MUL_XLO:
            begin
                mul_a = $signed({16'b0, x_reg[17:0]});
                mul_b = INV_GAIN_Q30;
            end
            MUL_XHI:
            begin
                mul_a = MA_W'($signed(x_reg[X_W-1:18]));
                mul_b = INV_GAIN_Q30;
            end
            MUL_YLO:
            begin
                mul_a = $signed({16'b0, y_reg[17:0]});
                mul_b = INV_GAIN_Q30;
            end
            MUL_YHI:
            begin
                mul_a = MA_W'($signed(y_reg[X_W-1:18]));
                mul_b = INV_GAIN_Q30;
            end
            MUL_RXDT:
            begin
                mul_a = rx_reg;
                mul_b = dt_b;
            end
            MUL_RYDT:
            begin
                mul_a = ry_reg;
                mul_b = dt_b;
            end
            MUL_WDT:
            begin
                mul_a = MA_W'(yaw_reg);
                mul_b = dt_b;
            end
            MUL_WBAM:
            begin
                mul_a = $signed(prod_reg[MA_W-1:0]);
                mul_b = RAD_TO_BAM_Q16;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tag_reg <= MUL_NONE;
        else
            tag_reg <= cmd.mul_op;
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    // product consumers
    logic [47:0]              g_sel;
    logic signed [67:0]       gsum;
    logic signed [PROD_W-1:0] dsum, bsum;

    assign g_sel = (tag_reg == MUL_YHI) ? gy_reg : gx_reg;
    assign gsum  = (68'($signed(prod_reg[47:0])) <<< 18) + $signed({20'b0, g_sel})
                 + 68'sd536870912;
    assign dsum  = prod_reg + 65'sd8388608;
    assign bsum  = prod_reg + 65'sd549755813888;

    always_ff @(posedge clk)
    begin
        case (tag_reg)
            MUL_XLO:  gx_reg <= prod_reg[47:0];
            MUL_YLO:  gy_reg <= prod_reg[47:0];
            MUL_XHI:  rx_reg <= gsum[63:30];
            MUL_YHI:  ry_reg <= gsum[63:30];
            MUL_RXDT: dx_reg <= dsum[57:24];
            MUL_RYDT: dy_reg <= dsum[57:24];
            MUL_WBAM: dh_reg <= bsum[55:40];
            default:  ;
        endcase
    end

    // pose update with saturation, or load of the initial pose
    logic signed [MA_W-1:0] sum_x, sum_y;
    logic signed [31:0]     px_next, py_next;
    logic [15:0]            ph_next;

    assign sum_x = MA_W'(pose_x_reg) + dx_reg;
    assign sum_y = MA_W'(pose_y_reg) + dy_reg;

    always_comb
    begin
        if (cmd.load)
        begin
            px_next = $signed(init_x);
            py_next = $signed(init_y);
            ph_next = init_heading;
        end
        else
        begin
            if (sum_x > MA_W'(POS_MAX))
                px_next = POS_MAX;
            else if (sum_x < MA_W'(POS_MIN))
                px_next = POS_MIN;
            else
                px_next = sum_x[31:0];
            if (sum_y > MA_W'(POS_MAX))
                py_next = POS_MAX;
            else if (sum_y < MA_W'(POS_MIN))
                py_next = POS_MIN;
            else
                py_next = sum_y[31:0];
            ph_next = pose_h_reg + dh_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pose_x_reg <= '0;
            pose_y_reg <= '0;
            pose_h_reg <= '0;
        end
        else if (cmd.write)
        begin
            pose_x_reg <= px_next;
            pose_y_reg <= py_next;
            pose_h_reg <= ph_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.write)
        begin
            pos_x_reg   <= px_next;
            pos_y_reg   <= py_next;
            heading_reg <= ph_next;
        end
    end

    assign pos_x   = pos_x_reg;
    assign pos_y   = pos_y_reg;
    assign heading = heading_reg;

endmodule

@@ rtl/core/pose_dead_reckoning_integrator_top.sv @@
// Planar dead-reckoning pose integrator: top level.
// Integrate beat: one rotator step per cycle, then seven slots of the shared multiplier,
// then the result is registered in ST_WRITE, which waits while out_stall holds an earlier one.
// The next beat is accepted in the cycle after the result is registered. Load beat: the
// initial pose is registered in ST_WRITE directly, and the next beat is accepted after it.
// Reset clears pose and initial-pose registers to zero; no output beat pending.
module pose_dead_reckoning_integrator_top
    import pdri_pkg::*;
#(
    parameter int CORDIC_ITERATIONS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               op,
    input  logic signed [15:0] vel_x,
    input  logic signed [15:0] vel_y,
    input  logic signed [15:0] yaw_rate,
    input  logic [15:0]        elapsed,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] pos_x,
    output logic signed [31:0] pos_y,
    output logic [15:0]        heading,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    cmd_t        cmd;
    logic [31:0] init_x;
    logic [31:0] init_y;
    logic [15:0] init_heading;

    pdri_regs u_regs (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .init_x       (init_x),
        .init_y       (init_y),
        .init_heading (init_heading)
    );

    pdri_ctrl #(
        .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .op        (op),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    pdri_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .vel_x        (vel_x),
        .vel_y        (vel_y),
        .yaw_rate     (yaw_rate),
        .elapsed      (elapsed),
        .init_x       (init_x),
        .init_y       (init_y),
        .init_heading (init_heading),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .heading      (heading)
    );

endmodule

@@ sim/tb_top.sv @@
// Self-checking testbench for the planar dead-reckoning pose integrator.
module tb_top
    import pdri_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int     NUM_ITER       = 16;
    localparam int     ATAN_STEPS     = 24;
    localparam int     WATCHDOG_LIMIT = 2000;
    localparam int     SETTLE_CYCLES  = 40;
    localparam int     HOLD_CYCLES    = 150;
    localparam logic   OP_INTEGRATE   = 1'b0;
    localparam logic   OP_LOAD        = 1'b1;
    localparam longint GAIN_COMP      = 64'sd652032874;
    localparam longint BAM_PER_RAD    = 64'sd683565276;
    localparam longint ROUND_24       = 64'sd8388608;
    localparam longint ROUND_30       = 64'sd536870912;
    localparam longint ROUND_40       = 64'sd549755813888;
    localparam longint POS_MAX        = 64'sd2147483647;
    localparam longint POS_MIN        = -64'sd2147483648;

    localparam longint ARCTAN [ATAN_STEPS] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
        64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
        64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D, 64'h000028BE, 64'h0000145F,
        64'h00000A30, 64'h00000518, 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
    };

    typedef struct packed {
        logic               op;
        logic signed [15:0] vx;
        logic signed [15:0] vy;
        logic signed [15:0] wz;
        logic [15:0]        dt;
    } tick_beat_t;

    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic [15:0]        hd;
    } pose_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic               op;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic signed [15:0] yaw_rate;
    logic [15:0]        elapsed;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [15:0]        heading;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [3:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    tick_beat_t  tick_q[$];
    pose_t       pose_expect_q[$];
    int          fail_count;
    int          hold_req;
    int          in_flight;
    bit          tx_idle;
    bit          rx_idle;

    logic signed [31:0] cfg_x;
    logic signed [31:0] cfg_y;
    logic [15:0]        cfg_h;
    logic signed [31:0] trk_x;
    logic signed [31:0] trk_y;
    logic [15:0]        trk_h;

    pose_dead_reckoning_integrator_top #(
        .CORDIC_ITERATIONS(NUM_ITER)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .op       (op),
        .vel_x    (vel_x),
        .vel_y    (vel_y),
        .yaw_rate (yaw_rate),
        .elapsed  (elapsed),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .pos_x    (pos_x),
        .pos_y    (pos_y),
        .heading  (heading),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    function automatic logic signed [31:0] clamp_pos(input longint s);
        if (s > POS_MAX)
            return 32'sh7FFFFFFF;
        if (s < POS_MIN)
            return 32'sh80000000;
        return s[31:0];
    endfunction

    function automatic pose_t advance_pose(input tick_beat_t t);
        longint      x;
        longint      y;
        longint      z;
        longint      xs;
        longint      ys;
        longint      rx;
        longint      ry;
        longint      dt;
        longint      dh;
        logic [15:0] h;
        logic [15:0] fold;
        pose_t       r;
        if (t.op == OP_LOAD)
        begin
            trk_x = cfg_x;
            trk_y = cfg_y;
            trk_h = cfg_h;
        end
        else
        begin
            x    = longint'(t.vx) * 65536;
            y    = longint'(t.vy) * 65536;
            h    = trk_h;
            fold = h + QUARTER_TURN;
            if (fold[15])
            begin
                x = -x;
                y = -y;
                h = h ^ HALF_TURN;
            end
            z = longint'($signed(h)) * 65536;
            for (int i = 0; i < NUM_ITER && i < ATAN_STEPS; i++)
            begin
                xs = x >>> i;
                ys = y >>> i;
                if (z >= 0)
                begin
                    x = x - ys;
                    y = y + xs;
                    z = z - ARCTAN[i];
                end
                else
                begin
                    x = x + ys;
                    y = y - xs;
                    z = z + ARCTAN[i];
                end
            end
            rx    = (x * GAIN_COMP + ROUND_30) >>> 30;
            ry    = (y * GAIN_COMP + ROUND_30) >>> 30;
            dt    = longint'({48'd0, t.dt});
            trk_x = clamp_pos(longint'(trk_x) + ((rx * dt + ROUND_24) >>> 24));
            trk_y = clamp_pos(longint'(trk_y) + ((ry * dt + ROUND_24) >>> 24));
            dh    = (longint'(t.wz) * dt * BAM_PER_RAD + ROUND_40) >>> 40;
            trk_h = trk_h + dh[15:0];
        end
        r.px = trk_x;
        r.py = trk_y;
        r.hd = trk_h;
        return r;
    endfunction

    function automatic tick_beat_t mk_tick(input logic o, input logic signed [15:0] vx,
                                           input logic signed [15:0] vy,
                                           input logic signed [15:0] wz, input logic [15:0] dt);
        tick_beat_t t;
        t.op = o;
        t.vx = vx;
        t.vy = vy;
        t.wz = wz;
        t.dt = dt;
        return t;
    endfunction

    function automatic tick_beat_t rand_tick();
        tick_beat_t t;
        int         mode;
        mode = $urandom_range(0, 3);
        t.op = ($urandom_range(0, 9) == 0) ? OP_LOAD : OP_INTEGRATE;
        t.vx = 16'($urandom());
        t.vy = 16'($urandom());
        t.wz = 16'($urandom());
        t.dt = 16'($urandom());
        if (mode == 1)
        begin
            t.vx = $signed(16'($urandom_range(0, 4095))) - 16'sd2048;
            t.vy = $signed(16'($urandom_range(0, 4095))) - 16'sd2048;
            t.wz = $signed(16'($urandom_range(0, 8191))) - 16'sd4096;
            t.dt = 16'($urandom_range(0, 1024));
        end
        else if (mode == 2)
        begin
            t.vx = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            t.vy = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            t.dt = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        end
        return t;
    endfunction

    task automatic send_tick(input tick_beat_t t);
        while (tick_q.size() >= 2)
            @(posedge clk);
        in_flight++;
        tick_q.push_back(t);
    endtask

    // every queued beat has been sent and its result taken
    task automatic wait_drain();
        while (in_flight != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        wait_drain();
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (idx)
            REG_INIT_X:       cfg_x = val;
            REG_INIT_Y:       cfg_y = val;
            REG_INIT_HEADING: cfg_h = val[15:0];
            default:          ;
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_init_pose(input logic [31:0] x, input logic [31:0] y,
                                 input logic [15:0] h);
        write_reg(REG_INIT_X, x);
        write_reg(REG_INIT_Y, y);
        write_reg(REG_INIT_HEADING, {16'h0000, h});
    endtask

    task automatic test_reset_state();
        send_tick(mk_tick(OP_INTEGRATE, 16'sh1234, -16'sh0567, 16'sh0100, 16'h0000));
        send_tick(mk_tick(OP_LOAD, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'hFFFF));
        send_tick(mk_tick(OP_INTEGRATE, 16'sh1000, 16'sh0000, 16'sh0000, 16'h1000));
    endtask

    task automatic test_quadrant_fold();
        logic [15:0] hlist [5];
        hlist = '{16'd16383, 16'd16384, 16'd32768, 16'd49151, 16'd49152};
        foreach (hlist[k])
        begin
            set_init_pose(32'h0001_0000, 32'hFFFF_0000, hlist[k]);
            send_tick(mk_tick(OP_LOAD, 16'sh0000, 16'sh0000, 16'sh0000, 16'h0000));
            send_tick(mk_tick(OP_INTEGRATE, 16'sh3039, -16'sh0929, 16'sh0200, 16'h1000));
        end
    endtask

    task automatic test_saturation();
        set_init_pose(32'h7FFF_FF00, 32'h8000_0100, 16'h0000);
        send_tick(mk_tick(OP_LOAD, 16'sh0000, 16'sh0000, 16'sh0000, 16'h0000));
        send_tick(mk_tick(OP_INTEGRATE, 16'sh7FFF, 16'sh8000, 16'sh0000, 16'hFFFF));
        set_init_pose(32'h8000_0100, 32'h7FFF_FF00, 16'h0000);
        send_tick(mk_tick(OP_LOAD, 16'sh0000, 16'sh0000, 16'sh0000, 16'h0000));
        send_tick(mk_tick(OP_INTEGRATE, 16'sh8000, 16'sh7FFF, 16'sh0000, 16'hFFFF));
    endtask

    task automatic test_heading_wrap();
        send_tick(mk_tick(OP_INTEGRATE, 16'sh0800, 16'sh0800, 16'sh7FFF, 16'hFFFF));
        send_tick(mk_tick(OP_INTEGRATE, 16'sh0800, 16'sh0800, 16'sh8000, 16'hFFFF));
        send_tick(mk_tick(OP_INTEGRATE, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'h0000));
        send_tick(mk_tick(OP_INTEGRATE, 16'shFFFF, 16'sh0001, 16'sh0001, 16'h0001));
    endtask

    task automatic test_backpressure();
        wait_drain();
        hold_req = HOLD_CYCLES;
        repeat (8)
            send_tick(rand_tick());
        wait_drain();
        repeat (6)
            send_tick(rand_tick());
    endtask

    task automatic test_random_ticks();
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0:       set_init_pose(32'h0000_0000, 32'h0000_0000, 16'h0000);
                1:       set_init_pose(32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF);
                2:       set_init_pose(32'h8000_0000, 32'h7FFF_FFFF, 16'h8000);
                default: set_init_pose($urandom(), $urandom(), 16'($urandom()));
            endcase
            tx_idle = (phase != 2);
            rx_idle = (phase != 2);
            send_tick(mk_tick(OP_LOAD, 16'sh0000, 16'sh0000, 16'sh0000, 16'h0000));
            repeat (200)
                send_tick(rand_tick());
        end
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    // beat source
    initial
    begin
        tick_beat_t cur;
        int         gap;
        in_valid = 1'b0;
        op       = OP_INTEGRATE;
        vel_x    = '0;
        vel_y    = '0;
        yaw_rate = '0;
        elapsed  = '0;
        cur      = '0;
        gap      = 0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (!(in_valid && in_stall))
            begin
                if (in_valid)
                begin
                    pose_expect_q.push_back(advance_pose(cur));
                    gap = tx_idle ? $urandom_range(0, 6) : 0;
                end
                if (gap > 0)
                begin
                    gap--;
                    in_valid <= 1'b0;
                end
                else if (tick_q.size() != 0)
                begin
                    cur = tick_q.pop_front();
                    in_valid <= 1'b1;
                    op       <= cur.op;
                    vel_x    <= cur.vx;
                    vel_y    <= cur.vy;
                    yaw_rate <= cur.wz;
                    elapsed  <= cur.dt;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result sink stalls
    initial
    begin
        int n;
        out_stall = 1'b0;
        wait (rst_n);
        forever
        begin
            if (hold_req > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold_req)
                    @(posedge clk);
                hold_req = 0;
            end
            n = rx_idle ? $urandom_range(0, 6) : 0;
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n)
                    @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!(out_valid && !out_stall))
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        pose_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            in_flight--;
            if (pose_expect_q.size() == 0)
            begin
                $error("result beat with no expected pose pending");
                fail_count++;
            end
            else
            begin
                e = pose_expect_q.pop_front();
                if (pos_x !== e.px)
                begin
                    $error("pos_x expected %0d got %0d", e.px, pos_x);
                    fail_count++;
                end
                if (pos_y !== e.py)
                begin
                    $error("pos_y expected %0d got %0d", e.py, pos_y);
                    fail_count++;
                end
                if (heading !== e.hd)
                begin
                    $error("heading expected %0d got %0d", e.hd, heading);
                    fail_count++;
                end
            end
        end
    end

    // watchdog: cycles without any accepted beat or register access
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        rst_n      = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        fail_count = 0;
        hold_req   = 0;
        in_flight  = 0;
        tx_idle    = 1'b1;
        rx_idle    = 1'b1;
        cfg_x      = '0;
        cfg_y      = '0;
        cfg_h      = '0;
        trk_x      = '0;
        trk_y      = '0;
        trk_h      = '0;
        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_quadrant_fold();
        test_saturation();
        test_heading_wrap();
        test_backpressure();
        test_random_ticks();

        wait_drain();
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
